// ----- src/symbol_run_length_encoder_defines.svh -----
// Assertion macros shared by the checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef SYMBOL_RUN_LENGTH_ENCODER_DEFINES_SVH
`define SYMBOL_RUN_LENGTH_ENCODER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SRE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/sre_pkg.sv -----
`default_nettype none

package sre_pkg;

    localparam int SRE_MAX_SYMBOL_BITS = 8;
    localparam int SRE_MAX_RUN_WIDTH   = 5;

    // Token queue depth and the most tokens one request can produce
    localparam int SRE_Q_DEPTH     = 8;
    localparam int SRE_MAX_RESULTS = 2;

    localparam logic [1:0] SRE_CODE_RESET = 2'd3;

    // Table entry width and default memory shape
    localparam int SRE_ENTRY_W   = 3;
    localparam int SRE_TBL_DEPTH = 256;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_DATA = 1'b1
    } sre_op_t;

    typedef struct packed {
        sre_op_t    operation;
        logic [7:0] symbol;
        logic [2:0] width_entry;
        logic       last;
    } sre_in_t;

    typedef struct packed {
        logic [7:0] token_symbol;
        logic [4:0] run_code;
        logic [2:0] run_width;
        logic [3:0] token_bits;
        logic       end_of_stream;
    } sre_out_t;

endpackage

`default_nettype wire

// ----- src/sre_ram.sv -----
`default_nettype none

module sre_ram
    import sre_pkg::*;
#(
    parameter int WIDTH = SRE_ENTRY_W,
    parameter int DEPTH = SRE_TBL_DEPTH,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- src/symbol_run_length_encoder.sv -----
`default_nettype none

// Channel   Direction  Handshake                Payload
// sym       in         sym_valid / sym_ready    sre_in_t  (operation, symbol, width, last)
// tok       out        tok_valid / tok_ready    sre_out_t (up to two tokens per request)
// cfg       in         cfg_we, no wait          cfg_wdata (symbol width code)
//
// One request per cycle while sym_ready is high; a request's tokens pass from
// the width table read stage into the token queue once it is taken.
// The width table memory has one read port: a config write steals it to
// re-read the pending run's entry, and sym_ready is low while it does.
// Reset clears the table through per-entry valid bits; there is no clearing
// pass. sym_ready drops while the token queue has no room for two more tokens
// per request in flight, so a stalled tok channel backs up into sym.

module symbol_run_length_encoder
    import sre_pkg::*;
#(
    parameter int MAX_SYMBOL_BITS = SRE_MAX_SYMBOL_BITS,
    parameter int MAX_RUN_WIDTH   = SRE_MAX_RUN_WIDTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       sym_valid,
    output logic            sym_ready,
    input  wire sre_in_t    sym,
    output logic            tok_valid,
    input  wire logic       tok_ready,
    output sre_out_t        tok,
    input  wire logic       cfg_we,
    input  wire logic [1:0] cfg_wdata
);

    localparam int TBL_DEPTH   = 1 << MAX_SYMBOL_BITS;
    localparam int IDX_W       = MAX_SYMBOL_BITS;
    localparam int RUN_LEN_W   = MAX_RUN_WIDTH + 1;
    localparam int Q_PTR_W     = $clog2(SRE_Q_DEPTH);
    localparam int Q_CNT_W     = Q_PTR_W + 1;
    localparam int READY_LIMIT = SRE_Q_DEPTH - 2 * SRE_MAX_RESULTS;

    // Configuration and derived symbol geometry
    logic [1:0] code_reg;
    logic [3:0] sym_bits_raw;
    logic [3:0] sym_bits;
    logic [7:0] sym_mask;

    // Input side
    logic             accept;
    logic [7:0]       in_sym_m;
    logic [IDX_W-1:0] in_idx;
    logic [2:0]       in_we_sat;
    logic [IDX_W-1:0] rd_idx;

    // Table memory and valid bits
    logic [TBL_DEPTH-1:0] tbl_vld_reg;
    logic                 rd_vld_reg;
    logic [2:0]           ram_q;
    logic                 tbl_we;
    logic [IDX_W-1:0]     s1_idx;

    // Request in the table-read stage
    logic       s1_valid_reg;
    sre_op_t    s1_op_reg;
    logic [7:0] s1_sym_reg;
    logic [2:0] s1_we_reg;
    logic       s1_last_reg;
    logic       fwd_hit_reg;
    logic       fwd_hit_next;
    logic [2:0] fwd_data_reg;

    // Pending run
    logic [7:0]           run_value_reg;
    logic [7:0]           run_value_next;
    logic [RUN_LEN_W-1:0] run_len_reg;
    logic [RUN_LEN_W-1:0] run_len_next;
    logic [2:0]           run_w_reg;
    logic [2:0]           run_w_next;

    // Width re-read after a config write
    logic refresh_reg;
    logic refresh_rd_reg;

    // Token assembly
    logic [2:0]           ent;
    logic [7:0]           rv_m;
    logic                 pending;
    logic                 flush;
    logic [RUN_LEN_W-1:0] base_len;
    logic [RUN_LEN_W-1:0] new_len;
    logic [RUN_LEN_W-1:0] limit;
    logic                 emit_run;
    logic                 main_emit;
    sre_out_t             flush_tok;
    sre_out_t             main_tok;
    sre_out_t             slot0;
    sre_out_t             slot1;
    logic [1:0]           npush;

    // Token queue
    sre_out_t           q_reg [SRE_Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg;
    logic [Q_PTR_W-1:0] rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;
    logic               pop;

    // Symbol size: 1 << code, clamped to the widest supported symbol
    always_comb
    begin
        sym_bits_raw = 4'd1 << code_reg;
        sym_bits     = sym_bits_raw;
        if (int'(sym_bits_raw) > MAX_SYMBOL_BITS)
        begin
            sym_bits = 4'(MAX_SYMBOL_BITS);
        end
        sym_mask = 8'((9'd1 << sym_bits) - 9'd1);
    end

    assign sym_ready = !refresh_reg && (count_reg <= Q_CNT_W'(READY_LIMIT));
    assign accept    = sym_valid && sym_ready;

    assign in_sym_m  = sym.symbol & sym_mask;
    assign in_idx    = in_sym_m[IDX_W-1:0];
    // Saturate oversized widths on load
    assign in_we_sat = (int'(sym.width_entry) > MAX_RUN_WIDTH) ? 3'(MAX_RUN_WIDTH)
                                                               : sym.width_entry;

    // Read the pending run's entry during a refresh, else the incoming symbol
    always_comb
    begin
        rv_m = run_value_reg & sym_mask;
        rd_idx = refresh_reg ? rv_m[IDX_W-1:0] : in_idx;
    end

    assign s1_idx = s1_sym_reg[IDX_W-1:0];
    assign tbl_we = s1_valid_reg && (s1_op_reg == OP_LOAD);

    sre_ram #(
        .WIDTH (3),
        .DEPTH (TBL_DEPTH)
    ) u_tbl (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (s1_idx),
        .wdata (s1_we_reg),
        .raddr (rd_idx),
        .rdata (ram_q)
    );

    // Forward a load in the read stage to a request reading the same entry
    assign fwd_hit_next = accept && tbl_we && (in_idx == s1_idx);

    // Assemble up to two tokens for the request in the read stage
    always_comb
    begin
        ent     = fwd_hit_reg ? fwd_data_reg : (rd_vld_reg ? ram_q : 3'd0);
        pending = (run_len_reg != '0);
        flush   = s1_valid_reg && pending
                  && ((s1_op_reg == OP_LOAD) || (s1_sym_reg != rv_m));

        flush_tok.token_symbol  = rv_m;
        flush_tok.run_code      = 5'(run_len_reg - RUN_LEN_W'(1));
        flush_tok.run_width     = run_w_reg;
        flush_tok.token_bits    = 4'(sym_bits + 4'(run_w_reg));
        flush_tok.end_of_stream = 1'b0;

        base_len = (flush || !pending) ? '0 : run_len_reg;
        new_len  = base_len + RUN_LEN_W'(1);
        limit    = RUN_LEN_W'(1) << ent;
        emit_run = (new_len >= limit) || s1_last_reg;

        main_tok.token_symbol  = s1_sym_reg;
        main_tok.run_code      = (ent == 3'd0) ? 5'd0 : 5'(new_len - RUN_LEN_W'(1));
        main_tok.run_width     = ent;
        main_tok.token_bits    = 4'(sym_bits + 4'(ent));
        main_tok.end_of_stream = s1_last_reg;

        main_emit = s1_valid_reg && (s1_op_reg == OP_DATA)
                    && ((ent == 3'd0) || emit_run);

        if (flush)
        begin
            slot0 = flush_tok;
            slot1 = main_tok;
            npush = main_emit ? 2'd2 : 2'd1;
        end
        else
        begin
            slot0 = main_tok;
            slot1 = main_tok;
            npush = main_emit ? 2'd1 : 2'd0;
        end
    end

    // Run state update
    always_comb
    begin
        run_len_next   = run_len_reg;
        run_value_next = run_value_reg;
        run_w_next     = run_w_reg;
        if (refresh_rd_reg)
        begin
            run_w_next = ent;
        end
        if (s1_valid_reg)
        begin
            if (s1_op_reg == OP_LOAD)
            begin
                run_len_next = '0;
            end
            else if (ent == 3'd0)
            begin
                // Raw symbol: drop the run only if it was flushed
                if (flush)
                begin
                    run_len_next = '0;
                end
            end
            else
            begin
                // Latch the symbol only when a new run starts
                if (flush || !pending)
                begin
                    run_value_next = s1_sym_reg;
                end
                run_w_next   = ent;
                run_len_next = emit_run ? '0 : new_len;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            code_reg       <= SRE_CODE_RESET;
            tbl_vld_reg    <= '0;
            rd_vld_reg     <= 1'b0;
            s1_valid_reg   <= 1'b0;
            fwd_hit_reg    <= 1'b0;
            run_value_reg  <= '0;
            run_len_reg    <= '0;
            run_w_reg      <= '0;
            refresh_reg    <= 1'b0;
            refresh_rd_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                code_reg <= cfg_wdata;
            end
            refresh_reg    <= cfg_we;
            refresh_rd_reg <= refresh_reg;
            if (tbl_we)
            begin
                tbl_vld_reg[s1_idx] <= 1'b1;
            end
            rd_vld_reg    <= tbl_vld_reg[rd_idx];
            s1_valid_reg  <= accept;
            fwd_hit_reg   <= fwd_hit_next;
            run_value_reg <= run_value_next;
            run_len_reg   <= run_len_next;
            run_w_reg     <= run_w_next;
        end
    end

    // Request payload for the read stage
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= sym.operation;
            s1_sym_reg  <= in_sym_m;
            s1_we_reg   <= in_we_sat;
            s1_last_reg <= sym.last;
        end
        fwd_data_reg <= s1_we_reg;
    end

    // Token queue: two writes, one read per cycle
    assign pop       = tok_valid && tok_ready;
    assign tok_valid = (count_reg != '0);
    assign tok       = q_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(npush);
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            count_reg <= count_reg + Q_CNT_W'(npush) - Q_CNT_W'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (npush != 2'd0)
        begin
            q_reg[wr_ptr_reg] <= slot0;
        end
        if (npush == 2'd2)
        begin
            q_reg[wr_ptr_reg + Q_PTR_W'(1)] <= slot1;
        end
    end

endmodule

`default_nettype wire

// ----- src/sre_checker.sv -----
`default_nettype none

`include "symbol_run_length_encoder_defines.svh"

module sre_checker
    import sre_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       sym_valid,
    input wire logic       sym_ready,
    input wire sre_in_t    sym,
    input wire logic       tok_valid,
    input wire logic       tok_ready,
    input wire sre_out_t   tok,
    input wire logic       cfg_we
);

    // Hold a stalled request
    `SRE_ASSERT_NEXT(a_sym_hold, sym_valid && !sym_ready, sym_valid && $stable(sym), "request changed while stalled")

    // Hold a stalled token
    `SRE_ASSERT_NEXT(a_tok_hold, tok_valid && !tok_ready, tok_valid && $stable(tok), "token changed while stalled")

    // Token always carries at least one symbol bit beyond its run field
    `SRE_ASSERT_SAME(a_tok_bits, tok_valid, tok.token_bits > 4'(tok.run_width), "token_bits too small")

    // No token is valid when reset is released
    `SRE_ASSERT_SAME(a_no_early_tok, $rose(rst_n), !tok_valid, "token out of reset")

    // A config write blocks requests for the width re-read
    `SRE_ASSERT_NEXT(a_cfg_stall, cfg_we, !sym_ready, "request taken during width re-read")

endmodule

bind symbol_run_length_encoder sre_checker u_sre_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .sym_valid (sym_valid),
    .sym_ready (sym_ready),
    .sym       (sym),
    .tok_valid (tok_valid),
    .tok_ready (tok_ready),
    .tok       (tok),
    .cfg_we    (cfg_we)
);

`default_nettype wire
